[rtl/core/deq_pkg.sv]
package deq_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_POP_FRONT  = 3'd1,
      OP_PUSH_BACK  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_DUMP       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

endpackage

[rtl/core/double_ended_queue.sv]
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+------------------------------
// request   | req_op, req_value_in                    | beat when start && !busy
// response  | rsp_value_out, rsp_status, rsp_last     | rsp_strobe, one cycle, no stall
//
// every result appears in the cycle after the beat (or dump read) that causes it
// push and pop leave busy low, so the next beat may follow at once
// a dump reads one entry per cycle through the single read port, so on a
// non-empty queue it emits occupancy results and holds busy high until its last read
// reset is synchronous and active high: empty queue, front at entry zero
// the receiver cannot stall, so nothing waits on the response side
module double_ended_queue import deq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_op,
   input  logic signed [DATA_W-1:0] req_value_in,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_value_out,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_OCC = CW'(DEPTH);
   localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [IW-1:0] front_ff, front_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [IW-1:0] pos_ff, pos_in;      // last entry read by a dump
   logic [CW-1:0] cnt_ff, cnt_in;      // dump reads still to issue

   // response pipe, one stage to line up with the memory read
   logic       vld_ff, vld_in;
   logic       sel_ff, sel_in;          // take value from memory
   status_type status_ff, status_in;
   logic       last_ff, last_in;

   // memory port
   logic                     wr_en;
   logic [IW-1:0]            wr_addr;
   logic                     rd_en;
   logic [IW-1:0]            rd_addr;
   logic signed [DATA_W-1:0] rd_data;

   logic          accept;
   logic          full;
   logic          empty;
   logic [IW-1:0] front_dec;
   logic [IW-1:0] front_inc;
   logic [IW-1:0] pos_dec;
   logic [SW-1:0] tail_sum;
   logic [SW-1:0] back_sum;
   logic [IW-1:0] tail_idx;
   logic [IW-1:0] back_idx;

   assign busy   = (state_ff == ST_DUMP);
   assign accept = start && !busy;
   assign full   = (occ_ff == FULL_OCC);
   assign empty  = (occ_ff == '0);

   // circular index arithmetic, wraps at DEPTH in both directions
   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
   assign pos_dec   = (pos_ff == '0) ? LAST_IDX : pos_ff - 1'b1;

   // first free slot behind the back, and the back element itself
   assign tail_sum = SW'(front_ff) + SW'(occ_ff);
   assign back_sum = tail_sum - 1'b1;
   assign tail_idx = (tail_sum >= DEPTH_S) ? IW'(tail_sum - DEPTH_S) : IW'(tail_sum);
   assign back_idx = (back_sum >= DEPTH_S) ? IW'(back_sum - DEPTH_S) : IW'(back_sum);

   always_comb begin
      state_in  = state_ff;
      front_in  = front_ff;
      occ_in    = occ_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      vld_in    = 1'b0;
      sel_in    = 1'b0;
      status_in = STAT_OK;
      last_in   = 1'b1;
      wr_en     = 1'b0;
      wr_addr   = front_dec;
      rd_en     = 1'b0;
      rd_addr   = front_ff;

      if (state_ff == ST_DUMP) begin
         // walk toward the front, one read per cycle
         rd_en   = 1'b1;
         rd_addr = pos_dec;
         pos_in  = pos_dec;
         cnt_in  = cnt_ff - 1'b1;
         vld_in  = 1'b1;
         sel_in  = 1'b1;
         last_in = (cnt_ff == CW'(1));
         if (cnt_ff == CW'(1)) begin
            state_in = ST_IDLE;
         end
      end else if (accept) begin
         case (op_type'(req_op))
            OP_PUSH_FRONT: begin
               vld_in = 1'b1;
               if (full) begin
                  status_in = STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
                  front_in = front_dec;
                  occ_in   = occ_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               vld_in = 1'b1;
               if (empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = front_ff;
                  sel_in   = 1'b1;
                  front_in = front_inc;
                  occ_in   = occ_ff - 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               vld_in = 1'b1;
               if (full) begin
                  status_in = STAT_FULL;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = tail_idx;
                  occ_in  = occ_ff + 1'b1;
               end
            end
            OP_POP_BACK: begin
               vld_in = 1'b1;
               if (empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = back_idx;
                  sel_in  = 1'b1;
                  occ_in  = occ_ff - 1'b1;
               end
            end
            OP_DUMP: begin
               vld_in = 1'b1;
               if (empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  // back element first, the rest follow from the dump state
                  rd_en   = 1'b1;
                  rd_addr = back_idx;
                  sel_in  = 1'b1;
                  pos_in  = back_idx;
                  cnt_in  = occ_ff - 1'b1;
                  last_in = (occ_ff == CW'(1));
                  if (occ_ff != CW'(1)) begin
                     state_in = ST_DUMP;
                  end
               end
            end
            default: begin
               // unused codes: beat taken, nothing happens
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         front_ff <= '0;
         occ_ff   <= '0;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         occ_ff   <= occ_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

   // payload side of the pipe, no reset needed
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      sel_ff    <= sel_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   deq_ram #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // pushes and errors carry zero
   assign rsp_strobe    = vld_ff;
   assign rsp_value_out = sel_ff ? rd_data : '0;
   assign rsp_status    = status_ff;
   assign rsp_last      = last_ff;

   // a dump in progress always has entries left and reads still to issue
   a_dump_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> (occ_ff != '0 && cnt_ff != '0))
      else $error("dump running on an empty queue");

   // occupancy never exceeds the store
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_OCC)
      else $error("occupancy beyond depth");

   // no result without a beat or a dump read in the cycle before
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept || busy))
      else $error("result without cause");

   // the queue does not change while a dump walks it
   a_dump_frozen: assert property (@(posedge clock) disable iff (reset)
      busy |=> ($stable(occ_ff) && $stable(front_ff)))
      else $error("queue changed during dump");

endmodule

[rtl/core/deq_ram.sv]
module deq_ram import deq_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IW-1:0]            wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [IW-1:0]            rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/sv/tb_top.sv]
module tb_top;
   import deq_pkg::*;

   // sizes and limits of the run
   localparam int DEPTH        = 16;
   localparam int RANDOM_BEATS = 200;
   localparam int STALL_LIMIT  = 400;           // cycles with neither a beat nor a result
   localparam int DRAIN_CYCLES = 2 * DEPTH + 8; // longer than the longest dump
   localparam int REPORT_CAP   = 200;

   // op codes the block ignores
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

   // extreme data values
   localparam logic signed [DATA_W-1:0] VAL_MAX  = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] VAL_MIN  = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_ZERO = 32'sh0000_0000;
   localparam logic signed [DATA_W-1:0] VAL_ONES = 32'shffff_ffff;

   // bias of the random op mix
   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      status_type               status;
      logic                     last;
   } deq_rsp_type;

   // shadow copy of the deque plus the results it still owes
   class deque_shadow_type;
      logic signed [DATA_W-1:0] slots [DEPTH];
      int unsigned              head;
      int unsigned              fill;
      deq_rsp_type              due [$];
      int unsigned              errors;

      function new();
         head   = 0;
         fill   = 0;
         errors = 0;
      endfunction

      function void add_due(logic signed [DATA_W-1:0] value, status_type status, logic last);
         deq_rsp_type r;
         r.value  = value;
         r.status = status;
         r.last   = last;
         due.push_back(r);
      endfunction

      // one accepted request beat: update the shadow, queue what the block owes
      function void apply_command(logic [2:0] op, logic signed [DATA_W-1:0] value);
         int unsigned pos;
         case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (fill == DEPTH) begin
                  add_due(VAL_ZERO, STAT_FULL, 1'b1);
               end else begin
                  if (op == OP_PUSH_FRONT) begin
                     head = (head + DEPTH - 1) % DEPTH;
                     slots[head] = value;
                  end else begin
                     slots[(head + fill) % DEPTH] = value;
                  end
                  fill++;
                  add_due(VAL_ZERO, STAT_OK, 1'b1);
               end
            end
            OP_POP_FRONT: begin
               if (fill == 0) begin
                  add_due(VAL_ZERO, STAT_EMPTY, 1'b1);
               end else begin
                  add_due(slots[head], STAT_OK, 1'b1);
                  head = (head + 1) % DEPTH;
                  fill--;
               end
            end
            OP_POP_BACK: begin
               if (fill == 0) begin
                  add_due(VAL_ZERO, STAT_EMPTY, 1'b1);
               end else begin
                  pos = (head + fill - 1) % DEPTH;
                  add_due(slots[pos], STAT_OK, 1'b1);
                  fill--;
               end
            end
            OP_DUMP: begin
               if (fill == 0) begin
                  add_due(VAL_ZERO, STAT_EMPTY, 1'b1);
               end else begin
                  for (int i = fill; i > 0; i--) begin
                     add_due(slots[(head + i - 1) % DEPTH], STAT_OK, (i == 1));
                  end
               end
            end
            default: ;
         endcase
      endfunction

      task report(string what);
         errors++;
         if (errors <= REPORT_CAP) begin
            $display("mismatch at %0t: %s", $realtime, what);
         end
      endtask

      // one response beat against the oldest owed result
      task match_result(logic signed [DATA_W-1:0] value, logic [1:0] status, logic last);
         deq_rsp_type want;
         if (due.size() == 0) begin
            report($sformatf("unexpected result value=%0d status=%0d last=%0d",
                             value, status, last));
            return;
         end
         want = due.pop_front();
         if (value !== want.value) begin
            report($sformatf("value_out %0d, wanted %0d", value, want.value));
         end
         if (status !== want.status) begin
            report($sformatf("status %0d, wanted %s", status, want.status.name()));
         end
         if (last !== want.last) begin
            report($sformatf("last %0d, wanted %0d", last, want.last));
         end
      endtask
   endclass

   // dut signals; the ones the bench drives are known from time zero
   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     start        = 1'b0;
   logic                     busy;
   logic [2:0]               req_op       = '0;
   logic signed [DATA_W-1:0] req_value_in = '0;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_value_out;
   logic [1:0]               rsp_status;
   logic                     rsp_last;

   deque_shadow_type shadow;
   int               quiet_cycles = 0;

   double_ended_queue #(.DEPTH(DEPTH)) u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_value_in  (req_value_in),
      .rsp_strobe    (rsp_strobe),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   // 20 unit clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // monitor: values seen here are the ones that held up to this edge,
   // since every driver, ours and the block's, updates with nonblocking writes.
   // results are checked before the same edge's request beat is noted, so a
   // spurious result can never be matched against the beat just taken
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            shadow.match_result(rsp_value_out, rsp_status, rsp_last);
         end
         if (start && busy === 1'b0) begin
            shadow.apply_command(req_op, req_value_in);
         end
      end
      // progress counter for the watchdog
      if (rsp_strobe === 1'b1 || (start && busy === 1'b0)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // watchdog: too long without any beat on either side
   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // present one request and hold it until the block takes it;
   // returns at the edge that accepted the beat
   task automatic send_beat(input logic [2:0] op, input logic signed [DATA_W-1:0] value);
      start        <= 1'b1;
      req_op       <= op;
      req_value_in <= value;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // sender gap; the request ports carry junk meanwhile
   task automatic hold_off(input int unsigned cycles);
      start        <= 1'b0;
      req_op       <= 3'($urandom);
      req_value_in <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   // occasional short gap between directed beats
   task automatic pace();
      if ($urandom_range(0, 3) == 0) begin
         hold_off($urandom_range(1, 4));
      end
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         2:       return VAL_ZERO;
         3:       return VAL_ONES;
         default: return $urandom;
      endcase
   endfunction

   // op mix leans toward pushes or pops so the fill level sweeps empty to full
   function automatic logic [2:0] pick_op(input int mode);
      int unsigned roll;
      int unsigned push_share;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         return 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      end
      if (roll < 12) begin
         return OP_DUMP;
      end
      push_share = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 25 : 50;
      if ($urandom_range(0, 99) < push_share) begin
         return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end
      return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
   endfunction

   initial begin
      int unsigned      sent;
      int unsigned      burst;
      int unsigned      gap;
      int               mode;
      logic [2:0]       op;

      shadow = new();

      // reset held from time zero, released on an edge
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: pops and a dump on an empty queue report empty
      send_beat(OP_POP_FRONT, VAL_ONES);
      send_beat(OP_POP_BACK, VAL_MAX);
      send_beat(OP_DUMP, VAL_MIN);
      pace();

      // extremes at both ends; the front push wraps the front pointer below zero
      send_beat(OP_PUSH_BACK, VAL_MAX);
      send_beat(OP_PUSH_FRONT, VAL_MIN);
      send_beat(OP_DUMP, VAL_ZERO);
      pace();

      // unused op code is ignored
      send_beat(OP_UNUSED_LAST, VAL_ONES);

      // pop back, then remove the only element from the front
      send_beat(OP_POP_BACK, VAL_ZERO);
      send_beat(OP_POP_FRONT, VAL_ZERO);
      pace();

      // fill from both ends, wrapping the store in both directions
      for (int i = 0; i < DEPTH; i++) begin
         send_beat(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK,
                   i[0] ? VAL_MIN + i : VAL_MAX - i);
      end

      // full queue drops pushes at either end, then a dump of every entry
      send_beat(OP_PUSH_FRONT, VAL_ONES);
      send_beat(OP_PUSH_BACK, VAL_ONES);
      pace();
      send_beat(OP_DUMP, VAL_ZERO);
      pace();

      // random bursts with random gaps; roughly one burst in four runs on
      // without a gap, so dumps get both back to back beats and idle slots
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 16);
         while (burst > 0 && sent < RANDOM_BEATS) begin
            mode = (sent / 25) % 3;
            op   = pick_op(mode);
            send_beat(op, pick_value());
            if (op < OP_UNUSED_FIRST) begin
               sent++;
            end
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            hold_off(gap);
         end
      end

      // drain: wait for every owed result, then watch for strays
      start <= 1'b0;
      while (shadow.due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (shadow.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
